// ===== rtl/core/sha_pkg.sv =====
// Shared types, codes and sizes of the segment heap allocator.
`timescale 1ns / 1ps
package sha_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int MAX_SEGMENTS = 64;
	localparam int OFF_W        = $clog2(HEAP_BYTES);
	localparam int LEN_W        = $clog2(HEAP_BYTES + 1);
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_NEXT  = 2'd1,
		FIT_BEST  = 2'd2,
		FIT_WORST = 2'd3
	} fit_mode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_BADFREE = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE,
		ST_FIN0,
		ST_FIN1,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic             free;
	} seg_t;

	typedef struct packed {
		logic        op;
		logic [16:0] req_size;
		logic [15:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_offset;
	} rsp_t;

	// Per-entry verdicts of the compare unit
	typedef struct packed {
		logic take_pick;
		logic take_hi;
		logic contains;
	} fit_flags_t;

endpackage

// ===== rtl/core/sha_fit_unit.sv =====
// Compare unit that judges one table entry against the current request.
`timescale 1ns / 1ps
module sha_fit_unit (
	input  sha_pkg::seg_t                 entry,
	input  logic                          op,
	input  logic [1:0]                    mode,
	input  logic [sha_pkg::LEN_W-1:0]     need,
	input  logic [sha_pkg::OFF_W-1:0]     where_off,
	input  logic [sha_pkg::OFF_W-1:0]     cursor,
	input  logic                          pick_vld,
	input  logic [sha_pkg::LEN_W-1:0]     pick_len,
	input  logic                          hi_vld,
	input  logic                          start_found,
	output sha_pkg::fit_flags_t           flags
);
	import sha_pkg::*;

	logic             fits;
	logic             contains;
	logic             started;
	logic [LEN_W-1:0] cur_dist;

	assign fits     = entry.free && (entry.len >= need);
	assign cur_dist = {1'b0, cursor} - {1'b0, entry.off};
	assign contains = (cursor >= entry.off) && (cur_dist < entry.len);
	assign started  = start_found || contains;

	always_comb begin
		flags = '0;
		flags.contains = contains;
		if (op == OP_FREE) begin
			flags.take_pick = !pick_vld && (entry.off == where_off);
		end else begin
			case (fit_mode_t'(mode))
				FIT_FIRST: flags.take_pick = fits && !pick_vld;
				FIT_NEXT: begin
					flags.take_pick = fits && !pick_vld;
					flags.take_hi   = fits && !hi_vld && started;
				end
				FIT_BEST:  flags.take_pick = fits && (!pick_vld || entry.len < pick_len);
				FIT_WORST: flags.take_pick = entry.free &&
					(!pick_vld || entry.len >= pick_len);
				default:   flags.take_pick = 1'b0;
			endcase
		end
	end

endmodule

// ===== rtl/core/segment_heap_allocator.sv =====
// Top level: segment table memory, scan/move sequencer and result register.
`timescale 1ns / 1ps
// One request at a time. Each request scans the used entries of the segment
// table once, one entry per cycle through the table's single read port; on
// success it then shifts the tail of the table by one entry per cycle to open
// a slot on a split or close one or two on a merge, then writes one or two
// entries. After reset the block writes the initial whole-heap segment before
// it takes its first item. fit_mode may be written whenever the block is idle
// and acts on the next item.
module segment_heap_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sha_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sha_pkg::rsp_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata
);
	import sha_pkg::*;

	state_t state_q, state_d;

	seg_t             mem [MAX_SEGMENTS];
	seg_t             rd_data;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	seg_t             wr_data;

	logic [1:0]       fit_mode_q;
	logic [CNT_W-1:0] count_q;
	logic [OFF_W-1:0] cursor_q;
	logic             cur_vld_q;

	logic             op_q;
	logic [1:0]       mode_q;
	logic [LEN_W-1:0] need_q;
	logic [OFF_W-1:0] where_q;

	logic [CNT_W-1:0] scan_idx_q;
	logic             ev_vld_s1;
	logic [IDX_W-1:0] ev_idx_s1;
	logic             pick_vld_q, hi_vld_q, start_found_q;
	logic [IDX_W-1:0] pick_idx_q, hi_idx_q;
	seg_t             pick_e_q, hi_e_q, prev_e_q, hprev_e_q, nxt_e_q;
	logic             grab_next_q, nxt_vld_q;
	fit_flags_t       flags;

	logic             mv_up_q;
	logic [1:0]       mv_r_q;
	logic [CNT_W-1:0] mv_dst_q, mv_lim_q, mv_src;
	logic             mv_act;
	logic             mv_vld_s1;
	logic [IDX_W-1:0] mv_dst_s1;

	logic [1:0]       res_status_q;
	logic [OFF_W-1:0] res_off_q;
	logic [CNT_W-1:0] cnt_new_q;
	logic             cur_upd_q;
	logic [IDX_W-1:0] wr0_idx_q, wr1_idx_q;
	seg_t             wr0_e_q, wr1_e_q;
	logic             wr1_vld_q;

	// decision, worked out from the scan results
	logic [1:0]       d_status;
	logic [OFF_W-1:0] d_off;
	logic [CNT_W-1:0] d_cnt;
	logic             d_cur;
	logic [IDX_W-1:0] d_wr0_idx, d_wr1_idx;
	seg_t             d_wr0_e, d_wr1_e;
	logic             d_wr1_vld, d_mv_up;
	logic [1:0]       d_mv_r;
	logic [CNT_W-1:0] d_mv_dst, d_mv_lim;

	logic             fp_vld;
	logic [IDX_W-1:0] fp_idx;
	seg_t             fp_e;
	logic [LEN_W-1:0] rest_len;
	logic             pf, nf;
	logic [LEN_W-1:0] merged_len;

	logic             scan_issue;
	logic             load_out;
	logic             out_valid_q;
	rsp_t             out_data_q;

	sha_fit_unit u_fit (
		.entry       (rd_data),
		.op          (op_q),
		.mode        (mode_q),
		.need        (need_q),
		.where_off   (where_q),
		.cursor      (cursor_q),
		.pick_vld    (pick_vld_q),
		.pick_len    (pick_e_q.len),
		.hi_vld      (hi_vld_q),
		.start_found (start_found_q),
		.flags       (flags)
	);

	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q < count_q);
	assign mv_src     = mv_up_q ? (mv_dst_q + CNT_W'(mv_r_q)) : (mv_dst_q - 1'b1);
	assign mv_act     = (state_q == ST_MOVE) &&
		(mv_up_q ? (mv_src < count_q) : (mv_dst_q >= mv_lim_q));
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = '{off: '0, len: LEN_W'(HEAP_BYTES), free: 1'b1};
			end
			ST_SCAN: rd_addr = scan_idx_q[IDX_W-1:0];
			ST_MOVE: begin
				rd_addr = mv_src[IDX_W-1:0];
				wr_en   = mv_vld_s1;
				wr_addr = mv_dst_s1;
				wr_data = rd_data;
			end
			ST_FIN0: begin
				wr_en   = 1'b1;
				wr_addr = wr0_idx_q;
				wr_data = wr0_e_q;
			end
			ST_FIN1: begin
				wr_en   = 1'b1;
				wr_addr = wr1_idx_q;
				wr_data = wr1_e_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: if (!scan_issue && !ev_vld_s1) state_d = ST_DECIDE;
			ST_DECIDE: state_d = (d_status == STAT_OK) ? ST_MOVE : ST_DONE;
			ST_MOVE: if (!mv_act && !mv_vld_s1) state_d = ST_FIN0;
			ST_FIN0: state_d = wr1_vld_q ? ST_FIN1 : ST_DONE;
			ST_FIN1: state_d = ST_DONE;
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		fp_vld = pick_vld_q;
		fp_idx = pick_idx_q;
		fp_e   = pick_e_q;
		if (fit_mode_t'(mode_q) == FIT_NEXT && hi_vld_q) begin
			fp_vld = 1'b1;
			fp_idx = hi_idx_q;
			fp_e   = hi_e_q;
		end
		if (fit_mode_t'(mode_q) == FIT_WORST && fp_e.len < need_q) begin
			fp_vld = 1'b0;
		end
		rest_len   = fp_e.len - need_q;
		pf         = (pick_idx_q != '0) && hprev_e_q.free;
		nf         = nxt_vld_q && nxt_e_q.free;
		merged_len = pick_e_q.len + (nf ? nxt_e_q.len : '0) + (pf ? hprev_e_q.len : '0);

		d_status  = STAT_OK;
		d_off     = '0;
		d_cnt     = count_q;
		d_cur     = 1'b0;
		d_wr0_idx = fp_idx;
		d_wr0_e   = fp_e;
		d_wr1_vld = 1'b0;
		d_wr1_idx = fp_idx + 1'b1;
		d_wr1_e   = '0;
		d_mv_up   = 1'b1;
		d_mv_r    = '0;
		d_mv_dst  = count_q;
		d_mv_lim  = '0;
		if (op_q == OP_ALLOC) begin
			if (need_q == '0 || !fp_vld) begin
				d_status = STAT_NOFIT;
			end else if (fp_e.len == need_q) begin
				d_off        = fp_e.off;
				d_cur        = 1'b1;
				d_wr0_e.free = 1'b0;
			end else if (count_q >= CNT_W'(MAX_SEGMENTS)) begin
				d_status = STAT_FULL;
			end else begin
				// open slot p+1 by shifting the tail up, then split
				d_off     = OFF_W'({1'b0, fp_e.off} + rest_len);
				d_cur     = 1'b1;
				d_cnt     = count_q + 1'b1;
				d_wr0_e   = '{off: fp_e.off, len: rest_len, free: 1'b1};
				d_wr1_vld = 1'b1;
				d_wr1_e   = '{off: d_off, len: need_q, free: 1'b0};
				d_mv_up   = 1'b0;
				d_mv_lim  = CNT_W'(fp_idx) + CNT_W'(2);
			end
		end else begin
			if (!pick_vld_q || pick_e_q.free) begin
				d_status = STAT_BADFREE;
			end else begin
				// merge with the lower and upper neighbors where free, drop the absorbed slots
				d_wr0_idx = pf ? (pick_idx_q - 1'b1) : pick_idx_q;
				d_wr0_e   = '{off: (pf ? hprev_e_q.off : pick_e_q.off),
					len: merged_len, free: 1'b1};
				d_mv_r    = {1'b0, pf} + {1'b0, nf};
				d_mv_dst  = pf ? CNT_W'(pick_idx_q) : (CNT_W'(pick_idx_q) + 1'b1);
				d_cnt     = count_q - CNT_W'(d_mv_r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			fit_mode_q  <= FIT_NEXT;
			count_q     <= CNT_W'(1);
			cursor_q    <= '0;
			cur_vld_q   <= 1'b0;
			ev_vld_s1   <= 1'b0;
			mv_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ev_vld_s1 <= scan_issue;
			mv_vld_s1 <= mv_act;
			if (cfg_we) begin
				fit_mode_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				count_q     <= cnt_new_q;
				if (cur_upd_q) begin
					cursor_q  <= res_off_q;
					cur_vld_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_idx_s1 <= scan_idx_q[IDX_W-1:0];
		mv_dst_s1 <= mv_dst_q[IDX_W-1:0];
		if (state_q == ST_IDLE) begin
			op_q          <= in_data.op;
			mode_q        <= fit_mode_q;
			need_q        <= in_data.req_size;
			where_q       <= in_data.free_offset;
			scan_idx_q    <= '0;
			pick_vld_q    <= 1'b0;
			hi_vld_q      <= 1'b0;
			start_found_q <= !cur_vld_q;
			grab_next_q   <= 1'b0;
			nxt_vld_q     <= 1'b0;
		end
		if (scan_issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (ev_vld_s1) begin
			prev_e_q <= rd_data;
			if (flags.contains) begin
				start_found_q <= 1'b1;
			end
			if (flags.take_pick) begin
				pick_vld_q  <= 1'b1;
				pick_idx_q  <= ev_idx_s1;
				pick_e_q    <= rd_data;
				hprev_e_q   <= prev_e_q;
				grab_next_q <= 1'b1;
			end else if (grab_next_q) begin
				nxt_e_q     <= rd_data;
				nxt_vld_q   <= 1'b1;
				grab_next_q <= 1'b0;
			end
			if (flags.take_hi) begin
				hi_vld_q <= 1'b1;
				hi_idx_q <= ev_idx_s1;
				hi_e_q   <= rd_data;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_status_q <= d_status;
			res_off_q    <= d_off;
			cnt_new_q    <= (d_status == STAT_OK) ? d_cnt : count_q;
			cur_upd_q    <= d_cur;
			wr0_idx_q    <= d_wr0_idx;
			wr0_e_q      <= d_wr0_e;
			wr1_vld_q    <= d_wr1_vld;
			wr1_idx_q    <= d_wr1_idx;
			wr1_e_q      <= d_wr1_e;
			mv_up_q      <= d_mv_up;
			mv_r_q       <= d_mv_r;
			mv_dst_q     <= d_mv_dst;
			mv_lim_q     <= d_mv_lim;
		end
		if (mv_act) begin
			mv_dst_q <= mv_up_q ? (mv_dst_q + 1'b1) : (mv_dst_q - 1'b1);
		end
		if (load_out) begin
			out_data_q.status         <= res_status_q;
			out_data_q.granted_offset <= res_off_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_W'(MAX_SEGMENTS)))
		else $error("segment count out of range");

	a_scan_inside: assert property (@(posedge clk) disable iff (!arst_n)
		ev_vld_s1 |-> (CNT_W'(ev_idx_s1) < count_q))
		else $error("scan read beyond table");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while busy");

	a_move_write_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		mv_vld_s1 |-> (state_q == ST_MOVE))
		else $error("table shift write outside move phase");

endmodule
